>>> rtl/assert_macros.svh
// Assertion macros for the block's own checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that ante implies cons in the same cycle.
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that ante implies cons in the next cycle.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dlc_pkg.sv
package dlc_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int LABEL_RANGE = 1024;

  localparam int LABEL_W = 10;
  localparam int NL_W    = 6;
  localparam int LAB_W   = $clog2(LABEL_RANGE);
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W   = $clog2(MAX_ITEMS);

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic [NL_W-1:0] new_label;
    logic            last_res;
    logic            overflow;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT_RS,
    ST_EMIT_RT,
    ST_EMIT_OUT,
    ST_EMIT_WAIT,
    ST_CLEAR
  } st_t;

endpackage

>>> rtl/dlc_ram.sv
module dlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/dense_label_compaction.sv
// Load: one label request per cycle, no result until the request marked last.
// End of set: scan sweeps the table from min to max, then each result goes through
// EMIT_RS, EMIT_RT, EMIT_OUT and EMIT_WAIT (held by out_stall), then min..max is cleared.
// The label table is a single-port-write memory swept one entry per cycle.
// Reset: synchronous, active low; a clearing pass over all LABEL_RANGE (1024) table
// entries follows reset, with in_stall high throughout.
`include "assert_macros.svh"

module dense_label_compaction (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dlc_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dlc_pkg::out_res_t out_data
);

  localparam int LAB_W = dlc_pkg::LAB_W;
  localparam int CNT_W = dlc_pkg::CNT_W;
  localparam int IDX_W = dlc_pkg::IDX_W;
  localparam int NL_W  = dlc_pkg::NL_W;

  dlc_pkg::st_t      state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LAB_W-1:0]  min_r, min_nxt;
  logic [LAB_W-1:0]  max_r, max_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LAB_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic              scan_done_r, scan_done_nxt;
  logic              pend_r, pend_nxt;
  logic [LAB_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic [LAB_W-1:0]  shift_r, shift_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [LAB_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [LAB_W-1:0]  clr_end_r, clr_end_nxt;
  logic              out_valid_r, out_valid_nxt;
  dlc_pkg::out_res_t out_data_r, out_data_nxt;

  logic              tab_we;
  logic [LAB_W-1:0]  tab_waddr;
  logic [LAB_W-1:0]  tab_wdata;
  logic [LAB_W-1:0]  tab_raddr;
  logic [LAB_W-1:0]  tab_rdata;

  logic              st_we;
  logic [LAB_W-1:0]  st_rdata;

  logic              in_acc;
  logic [LAB_W-1:0]  lab;
  logic              room;
  logic              k_last;

  assign in_stall  = (state_r != dlc_pkg::ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign lab       = LAB_W'(in_data.label % dlc_pkg::LABEL_RANGE);
  assign room      = (cnt_r < CNT_W'(dlc_pkg::MAX_ITEMS));
  assign k_last    = ((CNT_W'(k_r) + CNT_W'(1)) == cnt_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dlc_ram #(
    .WIDTH (LAB_W),
    .DEPTH (dlc_pkg::MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (lab),
    .raddr (k_r),
    .rdata (st_rdata)
  );

  dlc_ram #(
    .WIDTH (LAB_W),
    .DEPTH (dlc_pkg::LABEL_RANGE)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    ovf_nxt       = ovf_r;
    scan_addr_nxt = scan_addr_r;
    scan_done_nxt = scan_done_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    pend_last_nxt = pend_last_r;
    shift_nxt     = shift_r;
    k_nxt         = k_r;
    clr_addr_nxt  = clr_addr_r;
    clr_end_nxt   = clr_end_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tab_we        = 1'b0;
    tab_waddr     = lab;
    tab_wdata     = LAB_W'(1);
    tab_raddr     = scan_addr_r;
    st_we         = 1'b0;

    case (state_r)
      dlc_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            st_we   = 1'b1;
            tab_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
            if (lab < min_r) begin
              min_nxt = lab;
            end
            if (lab > max_r) begin
              max_nxt = lab;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last) begin
            state_nxt     = dlc_pkg::ST_SCAN;
            scan_addr_nxt = min_nxt;
            scan_done_nxt = 1'b0;
            pend_nxt      = 1'b0;
            shift_nxt     = '0;
            k_nxt         = '0;
          end
        end
      end

      dlc_pkg::ST_SCAN: begin
        tab_raddr = scan_addr_r;
        if (!scan_done_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = scan_addr_r;
          pend_last_nxt = (scan_addr_r == max_r);
          scan_done_nxt = (scan_addr_r == max_r);
          scan_addr_nxt = scan_addr_r + LAB_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (tab_rdata == '0) begin
            shift_nxt = shift_r + LAB_W'(1);
          end else begin
            tab_we    = 1'b1;
            tab_waddr = pend_addr_r;
            tab_wdata = shift_r;
          end
          if (pend_last_r) begin
            state_nxt = dlc_pkg::ST_EMIT_RS;
          end
        end
      end

      dlc_pkg::ST_EMIT_RS: begin
        state_nxt = dlc_pkg::ST_EMIT_RT;
      end

      dlc_pkg::ST_EMIT_RT: begin
        tab_raddr = st_rdata;
        state_nxt = dlc_pkg::ST_EMIT_OUT;
      end

      dlc_pkg::ST_EMIT_OUT: begin
        out_data_nxt.new_label = NL_W'(st_rdata - min_r - tab_rdata);
        out_data_nxt.last_res  = k_last;
        out_data_nxt.overflow  = ovf_r;
        out_valid_nxt          = 1'b1;
        state_nxt              = dlc_pkg::ST_EMIT_WAIT;
      end

      dlc_pkg::ST_EMIT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (k_last) begin
            state_nxt    = dlc_pkg::ST_CLEAR;
            clr_addr_nxt = min_r;
            clr_end_nxt  = max_r;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = dlc_pkg::ST_EMIT_RS;
          end
        end
      end

      dlc_pkg::ST_CLEAR: begin
        tab_we    = 1'b1;
        tab_waddr = clr_addr_r;
        tab_wdata = '0;
        if (clr_addr_r == clr_end_r) begin
          state_nxt = dlc_pkg::ST_LOAD;
          cnt_nxt   = '0;
          min_nxt   = LAB_W'(dlc_pkg::LABEL_RANGE - 1);
          max_nxt   = '0;
          ovf_nxt   = 1'b0;
        end else begin
          clr_addr_nxt = clr_addr_r + LAB_W'(1);
        end
      end

      default: begin
        state_nxt = dlc_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlc_pkg::ST_CLEAR;
      cnt_r       <= '0;
      min_r       <= LAB_W'(dlc_pkg::LABEL_RANGE - 1);
      max_r       <= '0;
      ovf_r       <= 1'b0;
      scan_done_r <= 1'b0;
      pend_r      <= 1'b0;
      shift_r     <= '0;
      k_r         <= '0;
      clr_addr_r  <= '0;
      clr_end_r   <= LAB_W'(dlc_pkg::LABEL_RANGE - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      ovf_r       <= ovf_nxt;
      scan_done_r <= scan_done_nxt;
      pend_r      <= pend_nxt;
      shift_r     <= shift_nxt;
      k_r         <= k_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_end_r   <= clr_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_last_r <= pend_last_nxt;
    out_data_r  <= out_data_nxt;
  end

  `CHK_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(dlc_pkg::MAX_ITEMS), "count past limit")
  `CHK_SAME(a_emit_idx, clk, rst_n, out_valid_r, CNT_W'(k_r) < cnt_r, "result index past count")
  `CHK_SAME(a_ovf_full, clk, rst_n, out_valid_r && out_data_r.overflow, cnt_r == CNT_W'(dlc_pkg::MAX_ITEMS), "overflow without full store")
  `CHK_SAME(a_scan_range, clk, rst_n, state_r == dlc_pkg::ST_SCAN && pend_r, pend_addr_r >= min_r && pend_addr_r <= max_r, "scan outside min..max")
  `CHK_NEXT(a_emit_next, clk, rst_n, out_valid_r && !out_stall && !out_data_r.last_res, state_r == dlc_pkg::ST_EMIT_RS, "no next result after take")

endmodule
